@@ rtl/gyro_bias_calibrator_defines.svh @@
// ----------------------------------------------------------------------------
// Gyro bias calibrator assertion macros
// Shared concurrent assertion forms for the calibrator RTL.
// ----------------------------------------------------------------------------
`ifndef GYRO_BIAS_CALIBRATOR_DEFINES_SVH
`define GYRO_BIAS_CALIBRATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GBC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/gbc_pkg.sv @@
// ----------------------------------------------------------------------------
// Gyro bias calibrator package
// Widths, constants and shared types of the calibrator datapath.
// ----------------------------------------------------------------------------
package gbc_pkg;

    // Samples averaged per round.
    localparam int SAMPLES_PER_ROUND = 50;
    localparam int NUM_AXES          = 3;

    localparam int SMP_W    = 16;
    localparam int AVG_FRAC = 8;
    localparam int AVG_W    = 25;
    localparam int SC_W     = $clog2(SAMPLES_PER_ROUND);
    localparam int SUM_W    = SMP_W + $clog2(SAMPLES_PER_ROUND);
    localparam int A_W      = SUM_W + AVG_FRAC;
    localparam int RCP_SHIFT = A_W;
    localparam int RCP_W    = A_W;
    localparam int PROD_W   = A_W + RCP_W;
    localparam int DIFF_W   = AVG_W + 1;
    localparam int DSQ1_W   = 2 * AVG_W;
    localparam int DSQ_W    = DSQ1_W + 2;
    localparam int WU_W     = 4;
    localparam int RC_W     = 7;
    localparam int THR_W    = 40;
    localparam int CFG_IDX_W = 2;

    // Reciprocal of the round length; the quotient estimate is at most one low.
    localparam logic [RCP_W-1:0] RCP =
        RCP_W'((64'd1 << RCP_SHIFT) / SAMPLES_PER_ROUND);
    localparam logic [A_W-1:0] HALF_N = A_W'(SAMPLES_PER_ROUND / 2);
    localparam logic [A_W-1:0] DIV_N  = A_W'(SAMPLES_PER_ROUND);
    localparam logic [SC_W-1:0] SC_LAST = SC_W'(SAMPLES_PER_ROUND - 1);

    // Register reset values.
    localparam logic [WU_W-1:0]  WARMUP_RST     = WU_W'(5);
    localparam logic [RC_W-1:0]  MAX_ROUNDS_RST = RC_W'(121);
    localparam logic [THR_W-1:0] THR_RST        = THR_W'(176266);

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_WARMUP     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ROUNDS = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = CFG_IDX_W'(2);

    // Result kinds.
    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef enum logic {
        FE_WARM,
        FE_AVG
    } t_fe_phase;

    // Per-stage pipeline control.
    typedef struct packed {
        logic valid;
        logic rnd_end;
    } t_ctl;

    // Control from the front end to each axis lane.
    typedef struct packed {
        logic en;
        logic acc_add;
        logic acc_end;
        logic prev_upd;
    } t_lane_ctl;

    // What a lane hands to the merging stage.
    typedef struct packed {
        logic [DSQ1_W-1:0]       dsq;
        logic signed [AVG_W-1:0] avg;
        logic signed [AVG_W-1:0] mean;
        logic signed [SMP_W-1:0] smp;
    } t_lane_res;

endpackage

@@ rtl/gbc_axis_lane.sv @@
// ----------------------------------------------------------------------------
// Gyro bias calibrator axis lane
// Accumulates one axis, forms the rounded Q.8 round average and the squared
// difference against the previous round.
// ----------------------------------------------------------------------------
module gbc_axis_lane import gbc_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_lane_ctl               i_ctl,
    input  logic signed [SMP_W-1:0] i_smp,
    output t_lane_res               o_res
);

    logic signed [SUM_W-1:0]    r_sum;
    logic signed [SUM_W-1:0]    sum_next;
    logic signed [SUM_W-1:0]    r1_sum;
    logic signed [SMP_W-1:0]    r1_smp, r2_smp, r3_smp, r4_smp, r5_smp;
    logic [SUM_W-1:0]           mag;
    logic [A_W-1:0]             a_val, r2_a, r3_a;
    logic                       r2_neg, r3_neg;
    logic [PROD_W-1:0]          prod, r3_prod;
    logic [A_W-1:0]             q_est, q_mul, rem, q_fix;
    logic signed [AVG_W-1:0]    avg, r_prev, r4_avg, r4_prev;
    logic signed [AVG_W-1:0]    mean, r5_avg, r5_mean;
    logic signed [DIFF_W-1:0]   diff, msum;
    logic signed [2*DIFF_W-1:0] sq;
    logic [DSQ1_W-1:0]          r5_dsq;

    assign sum_next = r_sum + SUM_W'(i_smp);

    // Round to nearest, ties away from zero: work on the magnitude.
    assign mag   = r1_sum[SUM_W-1] ? -r1_sum : r1_sum;
    assign a_val = {mag, {AVG_FRAC{1'b0}}} + HALF_N;

    assign prod  = PROD_W'(r2_a) * PROD_W'(RCP);

    // The estimate is exact or one low; the remainder fixes it.
    assign q_est = r3_prod[RCP_SHIFT +: A_W];
    assign q_mul = q_est * DIV_N;
    assign rem   = r3_a - q_mul;
    assign q_fix = (rem >= DIV_N) ? q_est + 1'b1 : q_est;
    assign avg   = r3_neg ? -$signed(AVG_W'(q_fix)) : $signed(AVG_W'(q_fix));

    assign diff  = DIFF_W'(r4_prev) - DIFF_W'(r4_avg);
    assign sq    = diff * diff;
    assign msum  = DIFF_W'(r4_avg) + DIFF_W'(r4_prev);
    assign mean  = AVG_W'(msum >>> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_prev <= '0;
        end else begin
            if (i_ctl.acc_add) begin
                r_sum <= i_ctl.acc_end ? '0 : sum_next;
            end
            if (i_ctl.prev_upd) begin
                r_prev <= avg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r1_sum  <= sum_next;
            r1_smp  <= i_smp;
            r2_a    <= a_val;
            r2_neg  <= r1_sum[SUM_W-1];
            r2_smp  <= r1_smp;
            r3_prod <= prod;
            r3_a    <= r2_a;
            r3_neg  <= r2_neg;
            r3_smp  <= r2_smp;
            r4_avg  <= avg;
            r4_prev <= r_prev;
            r4_smp  <= r3_smp;
            r5_dsq  <= DSQ1_W'(sq);
            r5_avg  <= r4_avg;
            r5_mean <= mean;
            r5_smp  <= r4_smp;
        end
    end

    assign o_res.dsq  = r5_dsq;
    assign o_res.avg  = r5_avg;
    assign o_res.mean = r5_mean;
    assign o_res.smp  = r5_smp;

endmodule

@@ rtl/gbc_merge.sv @@
// ----------------------------------------------------------------------------
// Gyro bias calibrator merging stage
// Sums the lane distances, runs the convergence decision and drives the
// output register.
// ----------------------------------------------------------------------------
module gbc_merge import gbc_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_lane_res               i_lane [NUM_AXES],
    input  t_ctl                    i_ctl,
    input  logic [RC_W-1:0]         i_max_rounds,
    input  logic [THR_W-1:0]        i_thr,
    input  logic                    i_out_ready,
    output logic                    o_stall,
    output logic                    o_out_valid,
    output logic                    o_result_kind,
    output logic signed [AVG_W-1:0] o_out_x,
    output logic signed [AVG_W-1:0] o_out_y,
    output logic signed [AVG_W-1:0] o_out_z,
    output logic                    o_cal_ok
);

    t_ctl                    r6_ctl;
    logic [DSQ_W-1:0]        dsq_sum, r6_dsq;
    logic signed [AVG_W-1:0] r6_avg  [NUM_AXES];
    logic signed [AVG_W-1:0] r6_mean [NUM_AXES];
    logic signed [SMP_W-1:0] r6_smp  [NUM_AXES];

    logic                    r_done, n_done;
    logic                    r_cal_ok, n_cal_ok;
    logic [RC_W-1:0]         r_rc, n_rc, rc_inc, limit;
    logic [DSQ_W-1:0]        r_best_dsq, n_best_dsq;
    logic signed [AVG_W-1:0] r_best_avg [NUM_AXES];
    logic signed [AVG_W-1:0] n_best_avg [NUM_AXES];
    logic signed [AVG_W-1:0] r_applied  [NUM_AXES];
    logic signed [AVG_W-1:0] n_applied  [NUM_AXES];
    logic signed [AVG_W-1:0] corrected  [NUM_AXES];

    logic                    emit, emit_kind, emit_ok;
    logic signed [AVG_W-1:0] emit_val [NUM_AXES];

    logic                    r_out_valid, r_out_kind, r_out_ok;
    logic signed [AVG_W-1:0] r_out_val [NUM_AXES];

    logic en;

    // Hold the pipe only when the last stage may produce a result that has
    // nowhere to go.
    assign o_stall = r6_ctl.valid && (r_done || r6_ctl.rnd_end)
                     && r_out_valid && !i_out_ready;
    assign en      = !o_stall;

    assign dsq_sum = DSQ_W'(i_lane[0].dsq) + DSQ_W'(i_lane[1].dsq)
                     + DSQ_W'(i_lane[2].dsq);

    assign rc_inc = r_rc + 1'b1;
    assign limit  = (i_max_rounds == '0) ? RC_W'(1) : i_max_rounds;

    always_comb begin
        for (int k = 0; k < NUM_AXES; k++) begin
            corrected[k] = (AVG_W'(r6_smp[k]) <<< AVG_FRAC)
                           - (r_cal_ok ? r_applied[k] : '0);
        end
    end

    always_comb begin
        n_done     = r_done;
        n_cal_ok   = r_cal_ok;
        n_rc       = r_rc;
        n_best_dsq = r_best_dsq;
        n_best_avg = r_best_avg;
        n_applied  = r_applied;
        emit       = 1'b0;
        emit_kind  = KIND_SAMPLE;
        emit_val   = corrected;
        if (r6_ctl.valid && en) begin
            if (r_done) begin
                emit = 1'b1;
            end else if (r6_ctl.rnd_end) begin
                if (r_rc == '0) begin
                    n_best_dsq = r6_dsq;
                    n_best_avg = r6_avg;
                end else if (r6_dsq < DSQ_W'(i_thr)) begin
                    n_applied = r6_mean;
                    n_cal_ok  = 1'b1;
                    n_done    = 1'b1;
                end else if (r6_dsq < r_best_dsq) begin
                    n_best_dsq = r6_dsq;
                    n_best_avg = r6_mean;
                end
                if (!n_done) begin
                    n_rc = rc_inc;
                    if (rc_inc >= limit) begin
                        n_applied = n_best_avg;
                        n_cal_ok  = 1'b0;
                        n_done    = 1'b1;
                    end
                end
                if (n_done) begin
                    emit      = 1'b1;
                    emit_kind = KIND_REPORT;
                    emit_val  = n_applied;
                end
            end
        end
        emit_ok = n_cal_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_ctl      <= '0;
            r_done      <= 1'b0;
            r_cal_ok    <= 1'b0;
            r_rc        <= '0;
            r_best_dsq  <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < NUM_AXES; k++) begin
                r_best_avg[k] <= '0;
                r_applied[k]  <= '0;
            end
        end else begin
            if (en) begin
                r6_ctl <= i_ctl;
            end
            r_done     <= n_done;
            r_cal_ok   <= n_cal_ok;
            r_rc       <= n_rc;
            r_best_dsq <= n_best_dsq;
            r_best_avg <= n_best_avg;
            r_applied  <= n_applied;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_dsq <= dsq_sum;
            for (int k = 0; k < NUM_AXES; k++) begin
                r6_avg[k]  <= i_lane[k].avg;
                r6_mean[k] <= i_lane[k].mean;
                r6_smp[k]  <= i_lane[k].smp;
            end
        end
        if (emit) begin
            r_out_kind <= emit_kind;
            r_out_ok   <= emit_ok;
            r_out_val  <= emit_val;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_out_kind;
    assign o_cal_ok      = r_out_ok;
    assign o_out_x       = r_out_val[0];
    assign o_out_y       = r_out_val[1];
    assign o_out_z       = r_out_val[2];

endmodule

@@ rtl/gyro_bias_calibrator.sv @@
// ----------------------------------------------------------------------------
// Gyro bias calibrator
// Use: three-axis raw gyro samples enter on the input channel (i_in_valid /
// o_in_ready). After the warm-up samples are dropped, rounds of samples are
// averaged; once consecutive round averages agree, or the round budget runs
// out, one report item (result_kind 0) carries the offset and cal_ok. Every
// later sample leaves as a corrected Q.8 item (result_kind 1). Warm-up and
// averaging samples produce no output item.
// Configuration: i_cfg_valid / o_cfg_ready with a register index and data;
// o_cfg_ready is always high and writes take effect on the next sample.
// Path: an item that produces a result passes the five lane stages, the
// merging stage and the output register before it shows on the output
// channel. Throughput: one item per cycle while the pipe is not stalled;
// the three axis lanes and the merging stage are fully pipelined.
// Stall: when the output register holds an untaken item and the last stage
// holds an item that may produce a result, the whole pipe and o_in_ready
// hold until i_out_ready rises; samples producing no output flow past freely.
// Reset: synchronous, active low; returns registers to their defaults and
// restarts the warm-up.
// ----------------------------------------------------------------------------
`include "gyro_bias_calibrator_defines.svh"

module gyro_bias_calibrator import gbc_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Sample input channel
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic signed [SMP_W-1:0]     i_gyro_x,
    input  logic signed [SMP_W-1:0]     i_gyro_y,
    input  logic signed [SMP_W-1:0]     i_gyro_z,
    // Result output channel
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_result_kind,
    output logic signed [AVG_W-1:0]     o_out_x,
    output logic signed [AVG_W-1:0]     o_out_y,
    output logic signed [AVG_W-1:0]     o_out_z,
    output logic                        o_cal_ok,
    // Configuration write channel
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [THR_W-1:0]            i_cfg_data
);

    // Configuration registers.
    logic [WU_W-1:0]  r_warmup_samples;
    logic [RC_W-1:0]  r_max_rounds;
    logic [THR_W-1:0] r_conv_thr;

    // Front-end sequencing of warm-up and round boundaries.
    t_fe_phase        r_phase, n_phase;
    logic [WU_W-1:0]  r_warmup_count, n_warmup_count;
    logic [SC_W-1:0]  r_sample_count, n_sample_count;
    logic             accum;
    logic             round_end;

    logic             stall;
    logic             en;
    logic             accept;

    // Control travelling alongside the lane stages one through five.
    t_ctl             r_ctl [1:5];

    t_lane_ctl               lane_ctl;
    logic signed [SMP_W-1:0] lane_smp [NUM_AXES];
    t_lane_res               lane_res [NUM_AXES];

    assign en          = !stall;
    assign o_in_ready  = en;
    assign accept      = i_in_valid && en;
    assign o_cfg_ready = 1'b1;

    // The configuration port never stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warmup_samples <= WARMUP_RST;
            r_max_rounds     <= MAX_ROUNDS_RST;
            r_conv_thr       <= THR_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_WARMUP:     r_warmup_samples <= i_cfg_data[WU_W-1:0];
                CFG_MAX_ROUNDS: r_max_rounds     <= i_cfg_data[RC_W-1:0];
                CFG_THRESHOLD:  r_conv_thr       <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= FE_WARM;
            r_warmup_count <= '0;
            r_sample_count <= '0;
        end else begin
            r_phase        <= n_phase;
            r_warmup_count <= n_warmup_count;
            r_sample_count <= n_sample_count;
        end
    end

    // The front end keeps counting rounds after the decision; the merging
    // stage ignores those round boundaries once calibration is finished.
    always_comb begin
        n_phase        = r_phase;
        n_warmup_count = r_warmup_count;
        n_sample_count = r_sample_count;
        accum          = 1'b0;
        unique case (r_phase)
            FE_WARM: begin
                if (r_warmup_count < r_warmup_samples) begin
                    if (accept) begin
                        n_warmup_count = r_warmup_count + 1'b1;
                    end
                end else begin
                    accum = 1'b1;
                    if (accept) begin
                        n_phase = FE_AVG;
                    end
                end
            end
            FE_AVG: begin
                accum = 1'b1;
            end
            default: begin
            end
        endcase
        round_end = accum && (r_sample_count == SC_LAST);
        if (accept && accum) begin
            n_sample_count = round_end ? '0 : r_sample_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= 5; k++) begin
                r_ctl[k] <= '0;
            end
        end else if (en) begin
            r_ctl[1].valid   <= accept;
            r_ctl[1].rnd_end <= accept && round_end;
            for (int k = 2; k <= 5; k++) begin
                r_ctl[k] <= r_ctl[k-1];
            end
        end
    end

    // Lanes latch the new previous average as a round boundary enters stage
    // four, so the next round always compares against it.
    assign lane_ctl.en       = en;
    assign lane_ctl.acc_add  = accept && accum;
    assign lane_ctl.acc_end  = round_end;
    assign lane_ctl.prev_upd = en && r_ctl[3].valid && r_ctl[3].rnd_end;

    assign lane_smp[0] = i_gyro_x;
    assign lane_smp[1] = i_gyro_y;
    assign lane_smp[2] = i_gyro_z;

    for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
        gbc_axis_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (lane_ctl),
            .i_smp   (lane_smp[g]),
            .o_res   (lane_res[g])
        );
    end

    gbc_merge u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_lane        (lane_res),
        .i_ctl         (r_ctl[5]),
        .i_max_rounds  (r_max_rounds),
        .i_thr         (r_conv_thr),
        .i_out_ready   (i_out_ready),
        .o_stall       (stall),
        .o_out_valid   (o_out_valid),
        .o_result_kind (o_result_kind),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_out_z       (o_out_z),
        .o_cal_ok      (o_cal_ok)
    );

    // With the output register empty there is never a reason to stall.
    `GBC_ASSERT_IMPL(a_ready_when_empty, i_clk, i_rst_n, !o_out_valid, o_in_ready, "input held while output register is empty")
    // A round boundary marker always rides on a real item.
    `GBC_ASSERT_IMPL(a_round_end_valid, i_clk, i_rst_n, r_ctl[1].rnd_end, r_ctl[1].valid, "round boundary on an empty stage")
    // An accepted round boundary restarts the sample count.
    `GBC_ASSERT_NEXT(a_count_restart, i_clk, i_rst_n, accept && round_end, r_sample_count == '0, "sample count not cleared after round")

endmodule

@@ sim/gbc_calib_checker.sv @@
// ----------------------------------------------------------------------------
// Gyro bias calibrator checker
// Follows the sample, result and register channels of the calibrator, keeps
// its own copy of the calibration state, and compares every result item
// with the one it predicts.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module gbc_calib_checker import gbc_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  logic signed [SMP_W-1:0] i_gyro_x,
    input  logic signed [SMP_W-1:0] i_gyro_y,
    input  logic signed [SMP_W-1:0] i_gyro_z,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  logic                    i_result_kind,
    input  logic signed [AVG_W-1:0] i_out_x,
    input  logic signed [AVG_W-1:0] i_out_y,
    input  logic signed [AVG_W-1:0] i_out_z,
    input  logic                    i_cal_ok,
    input  logic                    i_cfg_valid,
    input  logic                    i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [THR_W-1:0]        i_cfg_data,
    output int                      o_mismatches,
    output int                      o_waiting
);

    typedef enum logic [1:0] {
        CAL_WARMUP,
        CAL_AVERAGING,
        CAL_RUNNING
    } t_cal_phase;

    typedef struct packed {
        logic                    kind;
        logic signed [AVG_W-1:0] x;
        logic signed [AVG_W-1:0] y;
        logic signed [AVG_W-1:0] z;
        logic                    ok;
    } t_cal_out;

    // Register copies.
    logic [WU_W-1:0]  warmup_len;
    logic [RC_W-1:0]  round_budget;
    logic [THR_W-1:0] conv_limit_sq;

    // Calibration state.
    t_cal_phase              phase;
    logic [WU_W-1:0]         warm_cnt;
    logic [SC_W-1:0]         smp_cnt;
    logic [RC_W-1:0]         rnd_cnt;
    logic signed [SUM_W-1:0] axis_total [NUM_AXES];
    logic signed [AVG_W-1:0] prev_mean [NUM_AXES];
    logic signed [AVG_W-1:0] best_mean [NUM_AXES];
    logic [DSQ_W-1:0]        best_dsq;
    logic signed [AVG_W-1:0] bias [NUM_AXES];
    logic                    bias_ok;

    t_cal_out expected_q [$];
    int       mismatches = 0;

    assign o_mismatches = mismatches;

    // Round average in Q.8, rounded to nearest with ties away from zero.
    function automatic logic signed [AVG_W-1:0] round_mean_q8(
        input logic signed [SUM_W-1:0] total);
        logic signed [A_W-1:0] scaled;
        logic [A_W-1:0]        mag;
        logic [A_W-1:0]        quo;
        scaled = A_W'(total) <<< AVG_FRAC;
        mag = (scaled < 0) ? -scaled : scaled;
        quo = (mag + SAMPLES_PER_ROUND / 2) / SAMPLES_PER_ROUND;
        return (scaled < 0) ? -AVG_W'(quo) : AVG_W'(quo);
    endfunction

    // Mean of two averages, rounded toward minus infinity.
    function automatic logic signed [AVG_W-1:0] half_sum_floor(
        input logic signed [AVG_W-1:0] a, input logic signed [AVG_W-1:0] b);
        logic signed [AVG_W:0] total;
        total = a + b;
        return AVG_W'(total >>> 1);
    endfunction

    task automatic restore_defaults();
        warmup_len    = WARMUP_RST;
        round_budget  = MAX_ROUNDS_RST;
        conv_limit_sq = THR_RST;
        phase    = CAL_WARMUP;
        warm_cnt = '0;
        smp_cnt  = '0;
        rnd_cnt  = '0;
        best_dsq = '0;
        bias_ok  = 1'b0;
        for (int k = 0; k < NUM_AXES; k++) begin
            axis_total[k] = '0;
            prev_mean[k]  = '0;
            best_mean[k]  = '0;
            bias[k]       = '0;
        end
        expected_q.delete();
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [THR_W-1:0] data);
        case (idx)
            CFG_WARMUP:     warmup_len    = data[WU_W-1:0];
            CFG_MAX_ROUNDS: round_budget  = data[RC_W-1:0];
            CFG_THRESHOLD:  conv_limit_sq = data;
            default: ;
        endcase
    endtask

    task automatic queue_result(input logic kind,
                                input logic signed [AVG_W-1:0] v [NUM_AXES]);
        t_cal_out item;
        item.kind = kind;
        item.x    = v[0];
        item.y    = v[1];
        item.z    = v[2];
        item.ok   = bias_ok;
        expected_q.push_back(item);
    endtask

    task automatic report_bias();
        phase = CAL_RUNNING;
        queue_result(KIND_REPORT, bias);
    endtask

    task automatic absorb_sample(input logic signed [SMP_W-1:0] gx,
                                 input logic signed [SMP_W-1:0] gy,
                                 input logic signed [SMP_W-1:0] gz);
        logic signed [SMP_W-1:0] s [NUM_AXES];
        logic signed [AVG_W-1:0] mean [NUM_AXES];
        logic signed [AVG_W-1:0] corr [NUM_AXES];
        logic signed [AVG_W:0]   d;
        logic signed [DSQ_W-1:0] dd;
        logic [DSQ_W-1:0]        dsq;
        logic [RC_W-1:0]         limit;
        s[0] = gx;
        s[1] = gy;
        s[2] = gz;
        dsq = '0;

        if (phase == CAL_RUNNING) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                corr[k] = AVG_W'(s[k]) <<< AVG_FRAC;
                if (bias_ok) corr[k] = corr[k] - bias[k];
            end
            queue_result(KIND_SAMPLE, corr);
            return;
        end

        if (phase == CAL_WARMUP) begin
            if (warm_cnt < warmup_len) begin
                warm_cnt = warm_cnt + 1'b1;
                return;
            end
            phase = CAL_AVERAGING;
        end

        for (int k = 0; k < NUM_AXES; k++)
            axis_total[k] = axis_total[k] + s[k];
        smp_cnt = smp_cnt + 1'b1;
        if (smp_cnt < SAMPLES_PER_ROUND) return;

        for (int k = 0; k < NUM_AXES; k++) begin
            mean[k] = round_mean_q8(axis_total[k]);
            axis_total[k] = '0;
            d = prev_mean[k] - mean[k];
            dd = d;
            dsq = dsq + dd * dd;
        end
        smp_cnt = '0;

        // The first round only seeds the best guess, its distance is to zero.
        if (rnd_cnt == 0) begin
            best_dsq = dsq;
            for (int k = 0; k < NUM_AXES; k++) best_mean[k] = mean[k];
        end else if (dsq < conv_limit_sq) begin
            for (int k = 0; k < NUM_AXES; k++)
                bias[k] = half_sum_floor(mean[k], prev_mean[k]);
            bias_ok = 1'b1;
            report_bias();
            return;
        end else if (dsq < best_dsq) begin
            best_dsq = dsq;
            for (int k = 0; k < NUM_AXES; k++)
                best_mean[k] = half_sum_floor(mean[k], prev_mean[k]);
        end

        for (int k = 0; k < NUM_AXES; k++) prev_mean[k] = mean[k];
        rnd_cnt = rnd_cnt + 1'b1;

        limit = (round_budget == 0) ? RC_W'(1) : round_budget;
        if (rnd_cnt >= limit) begin
            for (int k = 0; k < NUM_AXES; k++) bias[k] = best_mean[k];
            bias_ok = 1'b0;
            report_bias();
        end
    endtask

    task automatic compare_field(input string name,
                                 input logic signed [AVG_W-1:0] want,
                                 input logic signed [AVG_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_result();
        t_cal_out want;
        if (expected_q.size() == 0) begin
            $display("%0t: unexpected result item, kind %0d x %0d y %0d z %0d",
                     $time, i_result_kind, i_out_x, i_out_y, i_out_z);
            mismatches++;
            return;
        end
        want = expected_q.pop_front();
        compare_field("result_kind", want.kind, i_result_kind);
        compare_field("out_x", want.x, i_out_x);
        compare_field("out_y", want.y, i_out_y);
        compare_field("out_z", want.z, i_out_z);
        compare_field("cal_ok", want.ok, i_cal_ok);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restore_defaults();
        end else begin
            if (i_cfg_valid && i_cfg_ready) write_register(i_cfg_index, i_cfg_data);
            if (i_out_valid && i_out_ready) check_result();
            if (i_in_valid && i_in_ready) absorb_sample(i_gyro_x, i_gyro_y, i_gyro_z);
        end
        o_waiting <= expected_q.size();
    end

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// Gyro bias calibrator testbench
// Drives one calibration per run, either towards convergence or towards a
// failed calibration once the round budget runs out, with register changes
// between rounds, then streams corrected samples. A separate checker predicts
// and compares every result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    import gbc_pkg::*;

    localparam int TOTAL_ITEMS   = 1150;
    localparam int CYCLE_LIMIT   = 200000;
    // Extra wait that lets the pipe run empty before touching registers.
    localparam int SETTLE_CYCLES = 12;
    localparam int ROUND_CAP     = 130;
    localparam int IDLE_PCT      = 23;
    // Post-report window in which neither side idles.
    localparam int CALM_FROM     = 600;
    localparam int CALM_TO       = 800;

    // Index with no register behind it; writes there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(3);
    localparam logic [THR_W-1:0]     THR_MAX   = '1;

    localparam logic signed [SMP_W-1:0] SMP_MAX = 16'sh7FFF;
    localparam logic signed [SMP_W-1:0] SMP_MIN = 16'sh8000;

    // Pattern buffers: two fixed rounds and one rebuilt for every noisy or random round.
    localparam int PAT_A       = 0;
    localparam int PAT_B       = 1;
    localparam int PAT_SCRATCH = 2;

    typedef enum logic [1:0] {
        STYLE_WIDE,
        STYLE_TOP,
        STYLE_BOTTOM,
        STYLE_NEAR
    } t_axis_style;

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_in_valid  = 1'b0;
    logic signed [SMP_W-1:0] i_gyro_x    = '0;
    logic signed [SMP_W-1:0] i_gyro_y    = '0;
    logic signed [SMP_W-1:0] i_gyro_z    = '0;
    logic                    i_out_ready = 1'b0;
    logic                    i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [THR_W-1:0]        i_cfg_data  = '0;

    logic                    o_in_ready;
    logic                    o_out_valid;
    logic                    o_result_kind;
    logic signed [AVG_W-1:0] o_out_x;
    logic signed [AVG_W-1:0] o_out_y;
    logic signed [AVG_W-1:0] o_out_z;
    logic                    o_cal_ok;
    logic                    o_cfg_ready;

    int   mismatches;
    int   results_waiting;
    int   items_sent  = 0;
    int   cycles      = 0;
    logic calm        = 1'b0;
    logic report_seen = 1'b0;

    logic signed [SMP_W-1:0] pattern [3][SAMPLES_PER_ROUND][NUM_AXES];

    gyro_bias_calibrator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_gyro_x      (i_gyro_x),
        .i_gyro_y      (i_gyro_y),
        .i_gyro_z      (i_gyro_z),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_result_kind (o_result_kind),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_out_z       (o_out_z),
        .o_cal_ok      (o_cal_ok),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    gbc_calib_checker calib_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_gyro_x      (i_gyro_x),
        .i_gyro_y      (i_gyro_y),
        .i_gyro_z      (i_gyro_z),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_result_kind (o_result_kind),
        .i_out_x       (o_out_x),
        .i_out_y       (o_out_y),
        .i_out_z       (o_out_z),
        .i_cal_ok      (o_cal_ok),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_mismatches  (mismatches),
        .o_waiting     (results_waiting)
    );

    // 8 ns clock period.
    always #4 i_clk = ~i_clk;

    // Watchdog: a run that hangs anywhere is a failed run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // The result side stalls at random, except inside the calm window.
    always @(posedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // The stimulus needs to know when the calibration report has left the block,
    // because from then on every sample produces a corrected item.
    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready && o_result_kind == KIND_REPORT)
            report_seen <= 1'b1;
    end

    // Mostly uniform over the whole field, with the extremes drawn often.
    function automatic logic signed [SMP_W-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return SMP_MAX;
            1:       return SMP_MIN;
            default: return SMP_W'($urandom);
        endcase
    endfunction

    // Offers one sample item and returns at the edge that accepts it. Valid is
    // left high so back-to-back items need no extra assignment; an idle gap
    // lowers it first.
    task automatic send_sample(input logic signed [SMP_W-1:0] gx,
                               input logic signed [SMP_W-1:0] gy,
                               input logic signed [SMP_W-1:0] gz);
        if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_gyro_x   <= gx;
        i_gyro_y   <= gy;
        i_gyro_z   <= gz;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    // One register write; the caller lowers valid after the last of a batch.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [THR_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Stops the sample stream, waits for every predicted item to come out and
    // then lets the pipe run empty, since samples without a result can still
    // be in flight.
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (results_waiting != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Builds one round of samples. A noisy round is uniform on every axis, so
    // its average wanders far from the last one; otherwise each axis gets a
    // style of its own: uniform, pinned to either extreme, or a small bias
    // with a little noise on it.
    task automatic fill_pattern(input int slot, input bit noisy);
        t_axis_style style;
        int          center;
        for (int a = 0; a < NUM_AXES; a++) begin
            style  = noisy ? STYLE_WIDE : t_axis_style'($urandom_range(0, 3));
            center = $urandom_range(0, 4000) - 2000;
            for (int i = 0; i < SAMPLES_PER_ROUND; i++) begin
                case (style)
                    STYLE_WIDE:   pattern[slot][i][a] = rand_sample();
                    STYLE_TOP:    pattern[slot][i][a] = SMP_MAX;
                    STYLE_BOTTOM: pattern[slot][i][a] = SMP_MIN;
                    default:
                        pattern[slot][i][a] = SMP_W'(center + $urandom_range(0, 100) - 50);
                endcase
            end
        end
    endtask

    task automatic send_pattern(input int slot);
        for (int i = 0; i < SAMPLES_PER_ROUND; i++)
            send_sample(pattern[slot][i][0], pattern[slot][i][1], pattern[slot][i][2]);
    endtask

    initial begin
        bit               converge_run;
        bit               alternate;
        int               noisy_rounds;
        int               rounds_done;
        int               wu_total;
        int               wu_sent;
        int               seed_round;
        logic [RC_W-1:0]  round_budget;
        logic [THR_W-1:0] word;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Each run takes one of two roads to the report. A converging run
        // starts with the threshold at zero so that no early round can agree,
        // sends up to two noisy rounds, then opens the threshold and repeats
        // one fixed round until two averages match. A failing run keeps the
        // threshold at zero after the first round and spends a small budget.
        converge_run = $urandom_range(0, 1);
        alternate    = $urandom_range(0, 1);
        if (converge_run) begin
            noisy_rounds = $urandom_range(0, 2);
            round_budget = ($urandom_range(0, 2) == 0) ? RC_W'(127)
                         : RC_W'($urandom_range(noisy_rounds + 2, 127));
        end else begin
            noisy_rounds = 0;
            // Zero budget must act like a budget of one.
            round_budget = RC_W'($urandom_range(0, 5));
        end

        // Warm-up length at its top, with every upper data bit set so that the
        // write only lands if the register masks to its own width.
        cfg_write(CFG_WARMUP, {{(THR_W - WU_W){1'b1}}, 4'hF});
        wu_total = 15;
        word = THR_W'({$urandom, $urandom});
        word[RC_W-1:0] = round_budget;
        cfg_write(CFG_MAX_ROUNDS, word);
        // The first round can never converge, so the widest threshold is
        // harmless in a failing run until it is closed after round one.
        cfg_write(CFG_THRESHOLD, converge_run ? '0 : THR_MAX);
        i_cfg_valid <= 1'b0;

        // Directed warm-up items at the extremes of every field. They are
        // dropped by the block, so no result may come from them.
        send_sample(SMP_MAX, SMP_MIN, 16'sh0000);
        send_sample(SMP_MIN, SMP_MAX, 16'shFFFF);
        send_sample(16'sh0000, 16'sh0001, SMP_MAX);
        send_sample(16'shFFFF, 16'shAAAA, SMP_MIN);
        send_sample(16'sh5555, 16'sh0000, 16'sh0001);
        send_sample(16'sh0001, 16'shFFFF, 16'sh5555);
        wu_sent = 6;
        settle();

        // Sometimes shorten the warm-up while it runs; if the count already
        // reached the new length, the very next sample starts round one.
        if ($urandom_range(0, 1)) begin
            wu_total = $urandom_range(0, 9);
            cfg_write(CFG_WARMUP, THR_W'(wu_total));
            i_cfg_valid <= 1'b0;
        end
        while (wu_sent < wu_total) begin
            send_sample(rand_sample(), rand_sample(), rand_sample());
            wu_sent++;
        end

        fill_pattern(PAT_A, 1'b0);
        fill_pattern(PAT_B, $urandom_range(0, 1));
        rounds_done = 0;
        seed_round  = (noisy_rounds == 0) ? 1 : noisy_rounds;

        while (!report_seen && rounds_done < ROUND_CAP) begin
            if (converge_run) begin
                if (rounds_done < noisy_rounds) begin
                    fill_pattern(PAT_SCRATCH, 1'b1);
                    send_pattern(PAT_SCRATCH);
                end else begin
                    send_pattern(PAT_A);
                end
            end else if (alternate) begin
                // Two fixed rounds in turn give the same distance every round,
                // which must not replace an equally close best guess.
                send_pattern(rounds_done % 2 == 0 ? PAT_A : PAT_B);
            end else begin
                fill_pattern(PAT_SCRATCH, $urandom_range(0, 1));
                send_pattern(PAT_SCRATCH);
            end
            rounds_done++;
            settle();

            if (!report_seen) begin
                if (converge_run && rounds_done == seed_round) begin
                    // Any nonzero threshold lets two equal averages agree.
                    case ($urandom_range(0, 2))
                        0:       word = THR_W'(1);
                        1:       word = THR_MAX;
                        default: word = THR_W'({$urandom, $urandom}) | THR_W'(1);
                    endcase
                    cfg_write(CFG_THRESHOLD, word);
                    i_cfg_valid <= 1'b0;
                end
                if (!converge_run && rounds_done == 1) begin
                    // A zero threshold never passes the strict compare, even
                    // for identical rounds.
                    cfg_write(CFG_THRESHOLD, '0);
                    // Cutting the budget down to the rounds already done makes
                    // the next round end the calibration.
                    if ($urandom_range(0, 1)) cfg_write(CFG_MAX_ROUNDS, THR_W'(1));
                    i_cfg_valid <= 1'b0;
                end
            end
        end

        // After the report the registers must have no effect on anything.
        cfg_write(CFG_WARMUP, THR_W'({$urandom, $urandom}));
        cfg_write(CFG_MAX_ROUNDS, THR_W'({$urandom, $urandom}));
        cfg_write(CFG_THRESHOLD, THR_W'({$urandom, $urandom}));
        cfg_write(CFG_SPARE, THR_W'({$urandom, $urandom}));
        i_cfg_valid <= 1'b0;

        // Directed corrected samples at the extremes of the fields.
        send_sample(SMP_MAX, SMP_MIN, 16'sh0000);
        send_sample(SMP_MIN, SMP_MAX, 16'shFFFF);
        send_sample(SMP_MIN, SMP_MIN, SMP_MIN);
        send_sample(SMP_MAX, SMP_MAX, SMP_MAX);
        send_sample(16'sh0001, 16'sh0000, 16'shAAAA);

        // Random corrected samples, with one stretch where neither side idles.
        while (items_sent < TOTAL_ITEMS) begin
            calm <= (items_sent >= CALM_FROM) && (items_sent < CALM_TO);
            send_sample(rand_sample(), rand_sample(), rand_sample());
        end
        calm <= 1'b0;
        settle();

        if (mismatches == 0 && results_waiting == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
